// File: hdl/ogds_pkg.sv
// ----------------------------------------------------------------------------
// ogds_pkg
// Shared types and codes for the occupancy grid disk stamp block: payload
// words, item modes, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package ogds_pkg;

    // Item modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_STAMP = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Register indexes on the write port
    localparam logic [2:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] CFG_CELLS_PER_M = 3'd2;
    localparam logic [2:0] CFG_GRID_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_GRID_HEIGHT = 3'd4;

    // Register reset values
    localparam logic [31:0] CELLS_PER_M_RESET = 32'd1310720;
    localparam logic [8:0]  GRID_DIM_RESET    = 9'd256;

    // Value written into every cell covered by a stamp
    localparam logic signed [7:0] MARK_VALUE = 8'sd100;

    // Input word
    typedef struct packed {
        logic [1:0]         mode;
        logic [15:0]        cell_index;
        logic signed [7:0]  cell_value;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [31:0]        diameter;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic signed [7:0] read_value;
        logic [11:0]       cells_marked;
    } out_word_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MULX,
        ST_MULY,
        ST_MULR,
        ST_RAD,
        ST_RSQ,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

// File: hdl/occupancy_grid_disk_stamp_top.sv
// ----------------------------------------------------------------------------
// occupancy_grid_disk_stamp_top
// Occupancy grid of signed bytes in one synchronous memory, with cell load,
// cell read and filled-disk stamping.
// ----------------------------------------------------------------------------
// One word is worked on at a time. A load passes the done state on its way to
// the result register, a read the read and done states. A stamp first turns
// the centre and the diameter into cells in the MULX, MULY and MULR states,
// which share one 32x32 multiplier; RAD saturates the radius in cells at
// MAX_RADIUS and RSQ squares it. Then the scan visits one candidate cell per
// cycle at the single memory write port, then the drain state empties the
// address stage. A new word is accepted as soon as the sequencer is back in
// idle, even while the previous result still waits in the output register. The
// grid memory has no reset; a cell must be loaded or stamped before it is read.
module occupancy_grid_disk_stamp_top #(
    parameter int MAX_CELLS  = 65536,
    parameter int MAX_RADIUS = 31
) (
    input  logic               clk,
    input  logic               rst_n,
    // input words
    input  logic               in_valid,
    output logic               in_stall,
    input  ogds_pkg::in_word_t in_data,
    // result words
    output logic               out_valid,
    input  logic               out_stall,
    output ogds_pkg::out_word_t out_data,
    // register writes
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int AW  = $clog2(MAX_CELLS);
    localparam int RW  = $clog2(MAX_RADIUS + 1);
    localparam int CW  = RW + 2;
    localparam int DW  = 2 * RW + 2;
    localparam int RSW = 2 * RW;
    localparam logic [20:0]   CELL_LIM = 21'(MAX_CELLS);
    localparam logic [RW-1:0] R_MAX    = RW'(MAX_RADIUS);

    // Configuration registers
    logic signed [31:0] origin_x_reg;
    logic signed [31:0] origin_y_reg;
    logic [31:0]        cpm_reg;
    logic [8:0]         grid_width_reg;
    logic [8:0]         grid_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            cpm_reg         <= ogds_pkg::CELLS_PER_M_RESET;
            grid_width_reg  <= ogds_pkg::GRID_DIM_RESET;
            grid_height_reg <= ogds_pkg::GRID_DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ogds_pkg::CFG_ORIGIN_X:    origin_x_reg    <= cfg_data;
                ogds_pkg::CFG_ORIGIN_Y:    origin_y_reg    <= cfg_data;
                ogds_pkg::CFG_CELLS_PER_M: cpm_reg         <= cfg_data;
                ogds_pkg::CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[8:0];
                ogds_pkg::CFG_GRID_HEIGHT: grid_height_reg <= cfg_data[8:0];
                default:                   ;
            endcase
        end
    end

    // Sequencer and datapath registers
    ogds_pkg::state_t state_reg, state_next;

    logic               idx_ok_reg;
    logic [31:0]        diameter_reg;
    logic [32:0]        mag_x_reg, mag_y_reg;
    logic               neg_x_reg, neg_y_reg;
    logic [63:0]        prod_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic [RW-1:0]      r_reg;
    logic [RSW-1:0]     rr_reg;
    logic signed [CW-1:0] i_reg, j_reg;
    logic [DW-1:0]      ii_reg, d_reg;
    logic               a_valid_reg;
    logic [8:0]         a_col_reg;
    logic [17:0]        a_prod_reg;
    logic signed [7:0]  res_read_reg;
    logic [11:0]        count_reg;
    logic               out_valid_reg;
    ogds_pkg::out_word_t out_data_reg;

    // Grid memory
    logic signed [7:0]  grid_mem [MAX_CELLS];
    logic signed [7:0]  rdata_reg;

    logic               in_accept;
    logic               out_load;
    logic               scan_last;
    logic               load_we, scan_we, mem_re;
    logic [20:0]        in_idx_w;
    logic               in_idx_ok;
    logic [AW-1:0]      waddr, raddr;
    logic signed [7:0]  wdata;

    // Accept-time centre offsets: 33-bit difference, then magnitude and sign
    logic signed [32:0] diff_x, diff_y;
    always_comb
    begin
        diff_x = 33'(in_data.center_x) - 33'(origin_x_reg);
        diff_y = 33'(in_data.center_y) - 33'(origin_y_reg);
    end

    // Shared multiplier operand and cell conversion
    logic [31:0]        mul_a;
    logic [32:0]        cells_w;
    logic signed [33:0] cell_s;
    logic [30:0]        rad_w;
    logic [RSW-1:0]     rsq_w;

    always_comb
    begin
        case (state_reg)
            ogds_pkg::ST_MULX: mul_a = mag_x_reg[31:0];
            ogds_pkg::ST_MULY: mul_a = mag_y_reg[31:0];
            default:           mul_a = diameter_reg;
        endcase
    end

    // Finish a centre product: add the top magnitude bit, then restore sign
    logic        fin_hi, fin_neg;
    always_comb
    begin
        fin_hi  = (state_reg == ogds_pkg::ST_MULY) ? mag_x_reg[32] : mag_y_reg[32];
        fin_neg = (state_reg == ogds_pkg::ST_MULY) ? neg_x_reg : neg_y_reg;
        cells_w = 33'(prod_reg[63:32]) + (fin_hi ? 33'(cpm_reg) : 33'd0);
        cell_s  = fin_neg ? (34'sd0 - $signed(34'(cells_w))) : $signed(34'(cells_w));
        rad_w   = prod_reg[63:33];
        rsq_w   = RSW'(r_reg) * RSW'(r_reg);
    end

    // Scan candidate: column, row, disk test
    logic signed [CW-1:0] r_s;
    logic signed [34:0]   col_s, row_s;
    logic                 col_ok, row_ok, disk_ok;
    logic [DW-1:0]        step_i, step_j, ii_step;

    always_comb
    begin
        r_s     = $signed(CW'(r_reg));
        col_s   = 35'(cx_reg) + 35'(i_reg);
        row_s   = 35'(cy_reg) + 35'(j_reg);
        col_ok  = !col_s[34] && (col_s[33:0] < 34'(grid_width_reg));
        row_ok  = !row_s[34] && (row_s[33:0] < 34'(grid_height_reg));
        disk_ok = d_reg <= DW'(rr_reg);
        step_i  = DW'(i_reg) + DW'(i_reg) + DW'(1);
        step_j  = DW'(j_reg) + DW'(j_reg) + DW'(1);
        ii_step = ii_reg + step_i;
        scan_last = (i_reg == r_s) && (j_reg == r_s);
    end

    // Address stage: linear address and store bound
    logic [18:0] addr_w;
    logic        addr_ok;
    always_comb
    begin
        addr_w  = 19'(a_prod_reg) + 19'(a_col_reg);
        addr_ok = 21'(addr_w) < CELL_LIM;
    end

    // Memory port control
    always_comb
    begin
        in_idx_w  = 21'(in_data.cell_index);
        in_idx_ok = in_idx_w < CELL_LIM;
        load_we   = in_accept && (in_data.mode == ogds_pkg::MODE_LOAD) && in_idx_ok;
        mem_re    = in_accept && (in_data.mode == ogds_pkg::MODE_READ);
        scan_we   = a_valid_reg && addr_ok;
        raddr     = in_idx_w[AW-1:0];
        if (scan_we)
        begin
            waddr = AW'(addr_w);
            wdata = ogds_pkg::MARK_VALUE;
        end
        else
        begin
            waddr = in_idx_w[AW-1:0];
            wdata = in_data.cell_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_we || scan_we)
        begin
            grid_mem[waddr] <= wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= grid_mem[raddr];
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ogds_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and handshake
    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        out_load   = 1'b0;
        case (state_reg)
            ogds_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    case (in_data.mode)
                        ogds_pkg::MODE_STAMP: state_next = ogds_pkg::ST_MULX;
                        ogds_pkg::MODE_READ:  state_next = ogds_pkg::ST_READ;
                        default:              state_next = ogds_pkg::ST_DONE;
                    endcase
                end
            end
            ogds_pkg::ST_READ:  state_next = ogds_pkg::ST_DONE;
            ogds_pkg::ST_MULX:  state_next = ogds_pkg::ST_MULY;
            ogds_pkg::ST_MULY:  state_next = ogds_pkg::ST_MULR;
            ogds_pkg::ST_MULR:  state_next = ogds_pkg::ST_RAD;
            ogds_pkg::ST_RAD:   state_next = ogds_pkg::ST_RSQ;
            ogds_pkg::ST_RSQ:   state_next = ogds_pkg::ST_SCAN;
            ogds_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ogds_pkg::ST_DRAIN;
                end
            end
            ogds_pkg::ST_DRAIN: state_next = ogds_pkg::ST_DONE;
            ogds_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ogds_pkg::ST_IDLE;
                end
            end
            default:            state_next = ogds_pkg::ST_IDLE;
        endcase
        in_accept = in_valid && !in_stall;
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ogds_pkg::ST_IDLE:
            begin
                idx_ok_reg   <= in_idx_ok;
                diameter_reg <= in_data.diameter;
                neg_x_reg    <= diff_x[32];
                neg_y_reg    <= diff_y[32];
                mag_x_reg    <= diff_x[32] ? (33'd0 - diff_x) : diff_x;
                mag_y_reg    <= diff_y[32] ? (33'd0 - diff_y) : diff_y;
                res_read_reg <= '0;
                count_reg    <= '0;
            end
            ogds_pkg::ST_READ:
            begin
                res_read_reg <= idx_ok_reg ? rdata_reg : 8'sd0;
            end
            ogds_pkg::ST_MULX:
            begin
                prod_reg <= 64'(mul_a) * 64'(cpm_reg);
            end
            ogds_pkg::ST_MULY:
            begin
                prod_reg <= 64'(mul_a) * 64'(cpm_reg);
                cx_reg   <= cell_s;
            end
            ogds_pkg::ST_MULR:
            begin
                prod_reg <= 64'(mul_a) * 64'(cpm_reg);
                cy_reg   <= cell_s;
            end
            ogds_pkg::ST_RAD:
            begin
                r_reg <= (rad_w > 31'(MAX_RADIUS)) ? R_MAX : RW'(rad_w);
            end
            ogds_pkg::ST_RSQ:
            begin
                rr_reg <= rsq_w;
                ii_reg <= DW'(rsq_w);
                d_reg  <= DW'(rsq_w) + DW'(rsq_w);
                i_reg  <= CW'(0) - CW'(r_reg);
                j_reg  <= CW'(0) - CW'(r_reg);
            end
            ogds_pkg::ST_SCAN:
            begin
                // inner walk over rows, outer over columns
                if (j_reg == r_s)
                begin
                    i_reg  <= i_reg + CW'(1);
                    j_reg  <= CW'(0) - CW'(r_reg);
                    ii_reg <= ii_step;
                    d_reg  <= ii_step + DW'(rr_reg);
                end
                else
                begin
                    j_reg <= j_reg + CW'(1);
                    d_reg <= d_reg + step_j;
                end
            end
            default: ;
        endcase

        // address stage operands
        a_col_reg  <= col_s[8:0];
        a_prod_reg <= 18'(row_s[8:0]) * 18'(grid_width_reg);

        // one cell marked per write
        if (scan_we)
        begin
            count_reg <= count_reg + 12'd1;
        end

        if (out_load)
        begin
            out_data_reg.read_value   <= res_read_reg;
            out_data_reg.cells_marked <= count_reg;
        end
    end

    // Control flags of the address stage and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= (state_reg == ogds_pkg::ST_SCAN) && col_ok && row_ok && disk_ok;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    a_scan_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_we |-> (state_reg == ogds_pkg::ST_SCAN || state_reg == ogds_pkg::ST_DRAIN))
        else $error("scan write outside the scan");

    a_stamp_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_data.mode == ogds_pkg::MODE_STAMP) |=> state_reg == ogds_pkg::ST_MULX)
        else $error("stamp did not start the multiply sequence");

    a_radius_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ogds_pkg::ST_SCAN |-> r_reg <= R_MAX)
        else $error("radius above limit");

    a_row_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ogds_pkg::ST_SCAN |-> (j_reg >= -r_s) && (j_reg <= r_s)
                                           && (i_reg >= -r_s) && (i_reg <= r_s))
        else $error("scan offset out of range");

    a_load_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> state_reg == ogds_pkg::ST_DONE && !a_valid_reg)
        else $error("result loaded while scan still pending");

endmodule
